// ===== design/assert_macros.svh =====
// Assertion macros for the checker file of this project.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define SPL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spl assertion failed");

// Next-cycle implication, disabled while reset is active.
`define SPL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spl assertion failed");

`endif

// ===== design/spl_pkg.sv =====
// Types and constants for the sliding peak limiter.
// No dependencies; used by every file of the block.
package spl_pkg;

  localparam int MAX_WINDOW = 1024;
  localparam logic [30:0] GAIN_ONE = 31'h4000_0000;
  localparam int CFG_W = 16;
  localparam int CFG_ADDR_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_LIMIT   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_RELEASE = 2'd2;

  // Divider step counts for the two divisions.
  localparam logic [4:0] DIV_STEPS_TARGET  = 5'd30;
  localparam logic [4:0] DIV_STEPS_RELEASE = 5'd31;

  typedef struct packed {
    logic signed [15:0] sample_in;
    logic               last_in_buffer;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic               last_out;
  } out_item_t;

  // Request to the shared divider.
  typedef struct packed {
    logic        start;
    logic [15:0] rem_init;
    logic [30:0] num;
    logic [15:0] den;
    logic [4:0]  steps;
  } div_req_t;

  // Divider result.
  typedef struct packed {
    logic        done;
    logic [30:0] quot;
  } div_rsp_t;

endpackage

// ===== design/sliding_peak_limiter.sv =====
// Sliding peak limiter: one sample at a time; each entry popped from the back
// of the peak queue adds to the time per sample. That time is set by the
// one-bit-per-cycle divider and the single-port reads of the queue memory.
// A result is held until transferred.
// Reset (rst_n, synchronous) restores the control and configuration registers,
// gain, queue and position; the queue memory itself is not cleared.
module sliding_peak_limiter #(
  parameter int MAX_WINDOW = spl_pkg::MAX_WINDOW
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  spl_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output spl_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [spl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [spl_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int SW = CW + 1;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_AGE   = 11'b000_0000_0010,
    S_TAIL  = 11'b000_0000_0100,
    S_POP   = 11'b000_0000_1000,
    S_PUSH  = 11'b000_0001_0000,
    S_PEAK  = 11'b000_0010_0000,
    S_TGT   = 11'b000_0100_0000,
    S_DIV1  = 11'b000_1000_0000,
    S_GAIN  = 11'b001_0000_0000,
    S_DIV2  = 11'b010_0000_0000,
    S_MUL   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [14:0] limit_r;
  logic [9:0]  window_r;
  logic [15:0] release_r;

  logic [AW-1:0] head_r;
  logic [CW-1:0] count_r;
  logic [30:0]   gain_r;
  logic [15:0]   pos_r;
  logic [15:0]   mag_r;
  logic          neg_r;
  logic          last_r;
  logic [30:0]   target_r;
  logic [46:0]   prod_r;
  logic          out_valid_r;
  spl_pkg::out_item_t out_data_r;

  logic [31:0]   ring_mem [MAX_WINDOW];
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0]   rd_data_r;
  logic [15:0]   rd_mag, rd_pos;

  logic          full;
  logic [AW-1:0] push_head;
  logic [CW-1:0] push_cnt;
  logic [15:0]   rel_eff;
  logic [16:0]   res_mag;
  logic [15:0]   res;
  logic          out_free;

  spl_pkg::div_req_t div_req;
  spl_pkg::div_rsp_t div_rsp;

  // Ring index: base plus offset, wrapped once.
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(MAX_WINDOW)) s = s - SW'(MAX_WINDOW);
    return s[AW-1:0];
  endfunction

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= 15'h7FFF;
      window_r  <= '0;
      release_r <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        spl_pkg::REG_LIMIT:   limit_r   <= cfg_wdata[14:0];
        spl_pkg::REG_WINDOW:  window_r  <= cfg_wdata[9:0];
        spl_pkg::REG_RELEASE: release_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign rel_eff  = (release_r == 16'd0) ? 16'd1 : release_r;
  assign rd_mag   = rd_data_r[31:16];
  assign rd_pos   = rd_data_r[15:0];
  assign full     = (count_r == CW'(MAX_WINDOW));
  assign push_head = full ? slot_of(head_r, CW'(1)) : head_r;
  assign push_cnt  = full ? CW'(MAX_WINDOW - 1) : count_r;
  assign out_free = !out_valid_r || out_ready;

  // Memory address selection per state.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head_r;
    wr_en   = 1'b0;
    wr_addr = slot_of(push_head, push_cnt);
    case (state_r)
      S_IDLE: rd_en = in_valid && (count_r != '0);
      S_TAIL: begin
        rd_en   = (count_r != '0);
        rd_addr = slot_of(head_r, count_r - CW'(1));
      end
      S_PUSH: wr_en = 1'b1;
      S_PEAK: rd_en = 1'b1;
      default: ;
    endcase
  end

  // Queue ring memory with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) ring_mem[wr_addr] <= {mag_r, pos_r};
    if (rd_en) rd_data_r <= ring_mem[rd_addr];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = (count_r != '0) ? S_AGE : S_TAIL;
      S_AGE:  state_nxt = S_TAIL;
      S_TAIL: state_nxt = (count_r != '0) ? S_POP : S_PUSH;
      S_POP:  state_nxt = (rd_mag <= mag_r) ? S_TAIL : S_PUSH;
      S_PUSH: state_nxt = S_PEAK;
      S_PEAK: state_nxt = S_TGT;
      S_TGT:  state_nxt = (rd_mag > {1'b0, limit_r}) ? S_DIV1 : S_GAIN;
      S_DIV1: if (div_rsp.done) state_nxt = S_GAIN;
      S_GAIN: state_nxt = (target_r < gain_r) ? S_MUL : S_DIV2;
      S_DIV2: if (div_rsp.done) state_nxt = S_MUL;
      S_MUL:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Divider requests for the target gain and the release step.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.rem_init = {1'b0, limit_r};
    div_req.num      = '0;
    div_req.den      = rd_mag;
    div_req.steps    = spl_pkg::DIV_STEPS_TARGET;
    case (state_r)
      S_TGT: div_req.start = (rd_mag > {1'b0, limit_r});
      S_GAIN: begin
        div_req.start    = !(target_r < gain_r);
        div_req.rem_init = '0;
        div_req.num      = target_r - gain_r;
        div_req.den      = rel_eff;
        div_req.steps    = spl_pkg::DIV_STEPS_RELEASE;
      end
      default: ;
    endcase
  end

  spl_divider u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign res_mag = prod_r[46:30];
  assign res     = neg_r ? 16'(-res_mag) : res_mag[15:0];

  // Queue control, gain and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      gain_r      <= spl_pkg::GAIN_ONE;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= (state_r == S_MUL && out_free) || (out_valid_r && !out_ready);
      case (state_r)
        S_AGE: begin
          if ((pos_r - rd_pos) > {6'd0, window_r}) begin
            head_r  <= slot_of(head_r, CW'(1));
            count_r <= count_r - CW'(1);
          end
        end
        S_POP: if (rd_mag <= mag_r) count_r <= count_r - CW'(1);
        S_PUSH: begin
          head_r  <= push_head;
          count_r <= push_cnt + CW'(1);
        end
        S_GAIN: if (target_r < gain_r) gain_r <= target_r;
        S_DIV2: if (div_rsp.done) gain_r <= gain_r + div_rsp.quot;
        S_MUL: begin
          if (out_free) begin
            if (last_r) begin
              head_r  <= '0;
              count_r <= '0;
              gain_r  <= spl_pkg::GAIN_ONE;
              pos_r   <= '0;
            end else begin
              pos_r <= pos_r + 16'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Sample capture, target gain, product and output payload.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      neg_r  <= in_data.sample_in[15];
      mag_r  <= in_data.sample_in[15] ? 16'(-in_data.sample_in) : in_data.sample_in;
      last_r <= in_data.last_in_buffer;
    end
    if (state_r == S_TGT) target_r <= spl_pkg::GAIN_ONE;
    if (state_r == S_DIV1 && div_rsp.done) target_r <= div_rsp.quot;
    if (state_r == S_DIV2 || (state_r == S_GAIN && target_r < gain_r)) begin
      prod_r <= 47'(mag_r) * 47'(state_r == S_DIV2 ? gain_r + div_rsp.quot : target_r);
    end
    if (state_r == S_MUL && out_free) begin
      out_data_r.sample_out <= res;
      out_data_r.last_out   <= last_r;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/spl_divider.sv =====
// Restoring divider, one quotient bit per cycle, shared by the gain logic.
// Depends on spl_pkg for the request and response types.
module spl_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  spl_pkg::div_req_t req,
  output spl_pkg::div_rsp_t rsp
);

  logic [15:0] rem_r;
  logic [30:0] num_r;
  logic [15:0] den_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [16:0] trial;
  logic        fits;

  // One trial subtraction per cycle.
  assign trial = {rem_r, num_r[30]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Quotient bits shift in as the dividend bits shift out.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem_init;
      num_r <= req.num;
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= fits ? 16'(trial - {1'b0, den_r}) : trial[15:0];
      num_r <= {num_r[29:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = num_r;

endmodule

// ===== design/spl_checker.sv =====
// Port-level checker for the sliding peak limiter, bound to the top level.
// Depends on spl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spl_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input spl_pkg::out_item_t out_data
);

  // A stalled result stays offered with the same payload.
  `SPL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `SPL_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data))

  // One sample at a time: no second transfer right after an input transfer.
  `SPL_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

  // A result never appears in the cycle after its input transfer.
  `SPL_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready && !out_valid, !out_valid)

endmodule

bind sliding_peak_limiter spl_checker u_spl_checker (
  .clk (clk),
  .rst_n (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data (out_data)
);
